// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sed_pkg.sv =====
// types and character constants for the string escape decoder
package sed_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_XL     = 8'h78;
	localparam logic [7:0] CH_XU     = 8'h58;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_AL     = 8'h61;
	localparam logic [7:0] CH_FL     = 8'h66;
	localparam logic [7:0] CH_AU     = 8'h41;
	localparam logic [7:0] CH_FU     = 8'h46;

	// up to two decoded bytes produced by one input character
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       two;     // byte1 follows byte0
		logic       valid0;  // 0 only for a bare end marker
		logic       fin;     // last record of the string
	} sed_rec_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} sed_hex_t;

	function automatic sed_hex_t hex_decode(input logic [7:0] c);
		sed_hex_t h;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (c >= CH_0 && c <= CH_9) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if ((c >= CH_AL && c <= CH_FL) || (c >= CH_AU && c <= CH_FU)) begin
			h.ok  = 1'b1;
			h.val = c[3:0] + 4'd9;
		end
		return h;
	endfunction

endpackage

// ===== rtl/sed_front.sv =====
// front end: escape state machine that turns each character into a record
module sed_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       in_byte,
	input  logic             final_byte,
	output logic             rec_push,
	output sed_pkg::sed_rec_t rec
);
	import sed_pkg::*;

	logic       esc_open_q, oct_mode_q, hex_mode_q;
	logic [1:0] digit_cnt_q;
	logic [8:0] esc_val_q;

	logic       esc_n, oct_n, hex_n;
	logic [1:0] cnt_n, cnt_t;
	logic [8:0] val_n, val_t;
	logic [1:0] n;
	logic [7:0] b0, b1, mapped;
	sed_hex_t   hv;
	logic       is_oct;

	always_comb begin
		esc_n  = esc_open_q;
		oct_n  = oct_mode_q;
		hex_n  = hex_mode_q;
		cnt_n  = digit_cnt_q;
		val_n  = esc_val_q;
		n      = 2'd0;
		b0     = 8'd0;
		b1     = 8'd0;
		hv     = hex_decode(in_byte);
		is_oct = (in_byte >= CH_0) && (in_byte <= CH_7);
		cnt_t  = digit_cnt_q + 2'd1;
		val_t  = 9'd0;
		mapped = in_byte;
		case (in_byte)
			CH_N:    mapped = CH_LF;
			CH_R:    mapped = CH_CR;
			CH_T:    mapped = CH_TAB;
			CH_B:    mapped = CH_BS;
			CH_F:    mapped = CH_FF;
			default: mapped = in_byte;
		endcase

		if (!esc_open_q) begin
			if (in_byte == CH_BSLASH) begin
				esc_n = 1'b1;
			end else begin
				b0 = in_byte;
				n  = 2'd1;
			end
		end else if (hex_mode_q) begin
			if (hv.ok) begin
				val_t = {esc_val_q[4:0], hv.val};
				if (cnt_t >= 2'd2) begin
					b0 = val_t[7:0];
					n  = 2'd1;
					esc_n = 1'b0; oct_n = 1'b0; hex_n = 1'b0; cnt_n = 2'd0; val_n = 9'd0;
				end else begin
					val_n = val_t;
					cnt_n = cnt_t;
				end
			end else begin
				if (digit_cnt_q != 2'd0) begin
					b0 = esc_val_q[7:0];
					n  = 2'd1;
				end
				esc_n = 1'b0; oct_n = 1'b0; hex_n = 1'b0; cnt_n = 2'd0; val_n = 9'd0;
				// terminating character is handled as plain text
				if (in_byte == CH_BSLASH) begin
					esc_n = 1'b1;
				end else if (n == 2'd0) begin
					b0 = in_byte;
					n  = 2'd1;
				end else begin
					b1 = in_byte;
					n  = 2'd2;
				end
			end
		end else if (oct_mode_q) begin
			if (is_oct) begin
				val_t = {esc_val_q[5:0], in_byte[2:0]};
				if (cnt_t == 2'd3 || cnt_t == 2'd0) begin
					b0 = val_t[7:0];
					n  = 2'd1;
					esc_n = 1'b0; oct_n = 1'b0; hex_n = 1'b0; cnt_n = 2'd0; val_n = 9'd0;
				end else begin
					val_n = val_t;
					cnt_n = cnt_t;
				end
			end else begin
				b0 = esc_val_q[7:0];
				n  = 2'd1;
				esc_n = 1'b0; oct_n = 1'b0; hex_n = 1'b0; cnt_n = 2'd0; val_n = 9'd0;
				if (in_byte == CH_BSLASH) begin
					esc_n = 1'b1;
				end else begin
					b1 = in_byte;
					n  = 2'd2;
				end
			end
		end else begin
			if (in_byte == CH_XL || in_byte == CH_XU) begin
				hex_n = 1'b1;
				cnt_n = 2'd0;
				val_n = 9'd0;
			end else if (is_oct) begin
				oct_n = 1'b1;
				cnt_n = 2'd1;
				val_n = {6'd0, in_byte[2:0]};
			end else begin
				b0 = mapped;
				n  = 2'd1;
				esc_n = 1'b0; oct_n = 1'b0; hex_n = 1'b0; cnt_n = 2'd0; val_n = 9'd0;
			end
		end

		// end of string: flush a pending octal value or a hex value with digits, then clear
		if (final_byte) begin
			if (esc_n && ((hex_n && cnt_n != 2'd0) || oct_n) && n != 2'd2) begin
				if (n == 2'd0) begin
					b0 = val_n[7:0];
					n  = 2'd1;
				end else begin
					b1 = val_n[7:0];
					n  = 2'd2;
				end
			end
			esc_n = 1'b0; oct_n = 1'b0; hex_n = 1'b0; cnt_n = 2'd0; val_n = 9'd0;
		end
	end

	always_comb begin
		rec.byte0  = b0;
		rec.byte1  = b1;
		rec.two    = (n == 2'd2);
		rec.valid0 = (n != 2'd0);
		rec.fin    = final_byte;
		rec_push   = accept && ((n != 2'd0) || final_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_open_q  <= 1'b0;
			oct_mode_q  <= 1'b0;
			hex_mode_q  <= 1'b0;
			digit_cnt_q <= 2'd0;
			esc_val_q   <= 9'd0;
		end else if (accept) begin
			esc_open_q  <= esc_n;
			oct_mode_q  <= oct_n;
			hex_mode_q  <= hex_n;
			digit_cnt_q <= cnt_n;
			esc_val_q   <= val_n;
		end
	end

endmodule

// ===== rtl/sed_queue.sv =====
// short record queue between the front end and the output side
module sed_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sed_pkg::sed_rec_t wdata,
	input  logic              pop,
	output sed_pkg::sed_rec_t rdata,
	output logic              full,
	output logic              empty
);
	import sed_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	sed_rec_t      mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/sed_back.sv =====
// back end: walks the bytes of the head record out one transfer at a time
module sed_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sed_pkg::sed_rec_t head,
	input  logic              q_empty,
	input  logic              pop,
	output logic              q_pop,
	output logic [7:0]        out_byte,
	output logic              byte_valid,
	output logic              run_last,
	output logic              string_end
);
	import sed_pkg::*;

	logic sel_q;
	logic last;

	assign last       = !head.two || sel_q;
	assign out_byte   = sel_q ? head.byte1 : head.byte0;
	assign byte_valid = sel_q || head.valid0;
	assign run_last   = last;
	assign string_end = last && head.fin;
	assign q_pop      = pop && !q_empty && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (pop && !q_empty) begin
			sel_q <= !last;
		end
	end

endmodule

// ===== rtl/string_escape_decoder.sv =====
// String escape decoder: one raw character of a string literal is taken per
// cycle (push while full is low) and the decoded characters come out of a
// result queue (pop while empty is low), one transfer per cycle. A character
// is decoded in the cycle it is taken and any bytes it gives (at most two) are
// queued as one record in the registered queue, whose head drives the output. A
// record with two bytes holds the output side for two transfers, so the input
// keeps its full rate until QUEUE_DEPTH records are waiting. The final
// character of a string always gives at least one result, the last of which has
// string_end set; with no byte to carry it is a bare marker with byte_valid low.
module string_escape_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       final_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       run_last,
	output logic       string_end
);
	import sed_pkg::*;

	sed_rec_t rec, head;
	logic     rec_push, q_pop, accept;

	assign accept = push && !full;

	sed_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.rec_push   (rec_push),
		.rec        (rec)
	);

	sed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec),
		.pop    (q_pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	sed_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (empty),
		.pop        (pop),
		.q_pop      (q_pop),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

// ===== rtl/sed_checker.sv =====
// port-level checks for the string escape decoder and their bind
`include "assert_macros.svh"

module sed_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       final_byte,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       run_last,
	input logic       string_end
);

	logic        fin_xfer;
	logic        bare_shown;
	logic        out_wait;
	logic [10:0] out_bus;

	assign fin_xfer   = push && !full && final_byte;
	assign bare_shown = !empty && !byte_valid;
	assign out_wait   = !empty && !pop;
	assign out_bus    = {out_byte, byte_valid, run_last, string_end};

	// a full queue always has something to show
	`ASSERT_IMP(a_full_not_empty, clk, arst_n, full, !empty, "full while empty")

	// the last character of a string always leaves a result behind
	`ASSERT_NXT(a_final_gives_result, clk, arst_n, fin_xfer, !empty, "no result for final")

	// a bare end marker only closes a string
	`ASSERT_IMP(a_bare_is_end, clk, arst_n, bare_shown, run_last && string_end, "bare not at end")

	// a result that is not taken stays put
	`ASSERT_NXT(a_hold, clk, arst_n, out_wait, !empty && $stable(out_bus), "waiting result changed")

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.push       (push),
	.full       (full),
	.final_byte (final_byte),
	.empty      (empty),
	.pop        (pop),
	.out_byte   (out_byte),
	.byte_valid (byte_valid),
	.run_last   (run_last),
	.string_end (string_end)
);

// ===== bench/string_escape_decoder_tb.sv =====
// self-checking testbench for the string escape decoder
module string_escape_decoder_tb;
	import sed_pkg::*;

	// one raw character for the input side, or a pause until all output has drained
	typedef struct {
		bit         drain;
		logic [7:0] ch;
		logic       fin;
	} raw_char_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       valid;
		logic       run_last;
		logic       str_end;
	} dec_char_t;

	localparam int IDLE_PCT      = 11;
	localparam int HOLD_CYCLES   = 120;
	localparam int WATCHDOG_MAX  = 3000;
	localparam int TARGET_CHARS  = 1350;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] in_byte = 8'h00;
	logic       final_byte = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       run_last;
	logic       string_end;

	raw_char_t raw_q[$];
	dec_char_t decoded_q[$];
	dec_char_t step_q[$];

	// decoder state as the bench predicts it
	logic       esc_open = 1'b0;
	logic       esc_oct = 1'b0;
	logic       esc_hex = 1'b0;
	logic [1:0] esc_digits = 2'd0;
	logic [8:0] esc_val = 9'd0;

	int chars_queued = 0;
	int chars_taken = 0;
	int chars_checked = 0;
	int mismatches = 0;
	int hold_left = 0;
	bit held = 1'b0;
	int quiet_cycles = 0;

	string_escape_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_byte    (in_byte),
		.final_byte (final_byte),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.run_last   (run_last),
		.string_end (string_end)
	);

	always #10 clk = ~clk;

	function automatic int hex_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
		return -1;
	endfunction

	task automatic emit(input logic [7:0] b);
		step_q.push_back('{ch: b, valid: 1'b1, run_last: 1'b0, str_end: 1'b0});
	endtask

	task automatic close_escape();
		esc_open = 1'b0;
		esc_oct = 1'b0;
		esc_hex = 1'b0;
		esc_digits = 2'd0;
		esc_val = 9'd0;
	endtask

	task automatic plain_char(input logic [7:0] c);
		if (c == CH_BSLASH)
			esc_open = 1'b1;
		else
			emit(c);
	endtask

	// advance the predicted state by one raw character and queue what it decodes to
	task automatic decode_char(input logic [7:0] c, input logic fin);
		int d;
		step_q.delete();
		if (!esc_open) begin
			plain_char(c);
		end else if (esc_hex) begin
			d = hex_value(c);
			if (d >= 0) begin
				esc_val = {esc_val[4:0], 4'(d)};
				esc_digits = esc_digits + 2'd1;
				if (esc_digits >= 2'd2) begin
					emit(esc_val[7:0]);
					close_escape();
				end
			end else begin
				if (esc_digits != 2'd0) emit(esc_val[7:0]);
				close_escape();
				plain_char(c);
			end
		end else if (esc_oct) begin
			if (c >= CH_0 && c <= CH_7) begin
				esc_val = {esc_val[5:0], c[2:0]};
				esc_digits = esc_digits + 2'd1;
				if (esc_digits == 2'd3 || esc_digits == 2'd0) begin
					emit(esc_val[7:0]);
					close_escape();
				end
			end else begin
				emit(esc_val[7:0]);
				close_escape();
				plain_char(c);
			end
		end else begin
			if (c == CH_XL || c == CH_XU) begin
				esc_hex = 1'b1;
				esc_digits = 2'd0;
				esc_val = 9'd0;
			end else if (c >= CH_0 && c <= CH_7) begin
				esc_oct = 1'b1;
				esc_digits = 2'd1;
				esc_val = {6'd0, c[2:0]};
			end else begin
				case (c)
					CH_N: emit(CH_LF);
					CH_R: emit(CH_CR);
					CH_T: emit(CH_TAB);
					CH_B: emit(CH_BS);
					CH_F: emit(CH_FF);
					default: emit(c);
				endcase
				close_escape();
			end
		end
		if (fin) begin
			// flush a pending octal value or a hex value with digits
			if (esc_open && ((esc_hex && esc_digits != 2'd0) || esc_oct) && step_q.size() < 2)
				emit(esc_val[7:0]);
			close_escape();
			if (step_q.size() == 0)
				step_q.push_back('{ch: 8'h00, valid: 1'b0, run_last: 1'b0, str_end: 1'b0});
			step_q[$].str_end = 1'b1;
		end
		if (step_q.size() != 0) step_q[$].run_last = 1'b1;
		foreach (step_q[i]) decoded_q.push_back(step_q[i]);
	endtask

	task automatic queue_char(input logic [7:0] c, input logic fin);
		raw_q.push_back('{drain: 1'b0, ch: c, fin: fin});
		chars_queued++;
	endtask

	task automatic queue_drain();
		raw_q.push_back('{drain: 1'b1, ch: 8'h00, fin: 1'b0});
	endtask

	task automatic queue_string(input string s);
		for (int i = 0; i < s.len(); i++) queue_char(s[i], i == s.len() - 1);
	endtask

	// mostly well-formed escapes with random content, some raw noise and broken tails
	task automatic queue_random_string();
		logic [7:0] s[$];
		string letters = "nrtbf\"'\\aqv89";
		string hexdig = "0123456789abcdefABCDEF";
		int pieces;
		int roll;
		int k;
		logic [7:0] c;
		pieces = $urandom_range(6, 1);
		for (int p = 0; p < pieces; p++) begin
			roll = $urandom_range(99);
			if (roll < 33) begin
				do c = 8'($urandom_range(8'h7E, 8'h20)); while (c == CH_BSLASH);
				s.push_back(c);
			end else if (roll < 52) begin
				s.push_back(CH_BSLASH);
				s.push_back(letters[$urandom_range(letters.len() - 1)]);
			end else if (roll < 72) begin
				s.push_back(CH_BSLASH);
				s.push_back($urandom_range(1) ? CH_XL : CH_XU);
				k = $urandom_range(2);
				for (int j = 0; j < k; j++) s.push_back(hexdig[$urandom_range(hexdig.len() - 1)]);
			end else if (roll < 87) begin
				s.push_back(CH_BSLASH);
				k = $urandom_range(3, 1);
				for (int j = 0; j < k; j++) s.push_back(CH_0 + 8'($urandom_range(7)));
			end else if (roll < 97) begin
				s.push_back(8'($urandom_range(255)));
			end else begin
				s.push_back(CH_BSLASH);
			end
		end
		foreach (s[i]) queue_char(s[i], i == s.size() - 1);
	endtask

	// sender: offers queued characters, pauses at drain markers
	always @(posedge clk) begin
		raw_char_t nxt;
		bit go;
		if (arst_n) begin
			if (push && !full) begin
				decode_char(in_byte, final_byte);
				chars_taken++;
			end
			if (!push || !full) begin
				if (raw_q.size() != 0 && raw_q[0].drain && decoded_q.size() == 0)
					void'(raw_q.pop_front());
				go = raw_q.size() != 0 && !raw_q[0].drain &&
					((chars_taken >= 600 && chars_taken < 800) ||
					$urandom_range(99) >= IDLE_PCT);
				if (go) begin
					nxt = raw_q.pop_front();
					in_byte <= nxt.ch;
					final_byte <= nxt.fin;
				end
				push <= go;
			end
		end
	end

	// receiver: checks each output transfer against the oldest prediction
	always @(posedge clk) begin
		dec_char_t want;
		bit ready;
		if (arst_n) begin
			if (pop && !empty) begin
				chars_checked++;
				if (decoded_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output: byte %h valid %b run_last %b string_end %b",
							out_byte, byte_valid, run_last, string_end);
				end else begin
					want = decoded_q.pop_front();
					if (out_byte !== want.ch || byte_valid !== want.valid ||
						run_last !== want.run_last || string_end !== want.str_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("output %0d: expected %h %b %b %b, got %h %b %b %b",
								chars_checked, want.ch, want.valid, want.run_last,
								want.str_end, out_byte, byte_valid, run_last, string_end);
					end
				end
			end
			// one long hold-off so the block fills and stalls its input
			if (hold_left != 0) begin
				hold_left--;
			end else if (!held && chars_checked >= 300) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			ready = hold_left == 0 && ((chars_checked >= 600 && chars_checked < 800) ||
				$urandom_range(99) >= IDLE_PCT);
			pop <= ready;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_MAX) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		// directed: escape letters, hex letters, octal overflow, early ends, final flushes
		queue_string("\\b\\f\\xbF");
		queue_string("\\777\\8");
		queue_string("\\x5g");
		queue_string("\\xz\\");
		queue_string("\\12");
		queue_string("\\x");
		queue_char(8'h00, 1'b0);
		queue_char(8'hFF, 1'b1);
		queue_drain();
		while (chars_queued < TARGET_CHARS) begin
			queue_random_string();
			if (chars_queued >= 700 && chars_queued < 720) queue_drain();
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (raw_q.size() != 0 || push) @(posedge clk);
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/sed_pkg.sv
rtl/sed_front.sv
rtl/sed_queue.sv
rtl/sed_back.sv
rtl/string_escape_decoder.sv
rtl/sed_checker.sv
bench/string_escape_decoder_tb.sv
